### rtl/tale_pkg.sv
package tale_pkg;

  localparam int TALE_CAPACITY = 1024;
  localparam int TALE_DATA_W   = 64;
  localparam int TALE_INDEX_W  = 10;
  localparam int TALE_COUNT_W  = 11;
  localparam int TALE_TDATA_W  = 80;

  // command codes
  localparam logic [1:0] CMD_SET    = 2'd0;
  localparam logic [1:0] CMD_GET    = 2'd1;
  localparam logic [1:0] CMD_PUSH   = 2'd2;
  localparam logic [1:0] CMD_REMOVE = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // element type after reset: 32-bit signed
  localparam logic [2:0] TYPE_INT = 3'd4;

  // width class, taken from the upper two bits of the element type
  localparam logic [1:0] WCLS_8  = 2'd0;
  localparam logic [1:0] WCLS_16 = 2'd1;
  localparam logic [1:0] WCLS_32 = 2'd2;
  localparam logic [1:0] WCLS_64 = 2'd3;

  typedef struct packed {
    logic load_in;
    logic set_status;
    logic wr_set;
    logic wr_push;
    logic rd_get;
    logic rd_first;
    logic shift_step;
    logic rd_next;
    logic capture_rd;
    logic dec_count;
    logic load_out;
  } tale_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       idx_ok;
    logic       full;
    logic       more_first;
    logic       more_next;
    logic       out_free;
  } tale_stat_t;

  function automatic logic [TALE_DATA_W-1:0] tale_cut(input logic [TALE_DATA_W-1:0] v,
                                                      input logic [2:0] t);
    logic [TALE_DATA_W-1:0] res;
    case (t[2:1])
      WCLS_8:  res = {56'd0, v[7:0]};
      WCLS_16: res = {48'd0, v[15:0]};
      WCLS_32: res = {32'd0, v[31:0]};
      default: res = v;
    endcase
    return res;
  endfunction

  function automatic logic [TALE_DATA_W-1:0] tale_extend(input logic [TALE_DATA_W-1:0] v,
                                                         input logic [2:0] t);
    logic                   sg;
    logic [TALE_DATA_W-1:0] res;
    sg = ~t[0];
    case (t[2:1])
      WCLS_8:  res = {{56{sg & v[7]}}, v[7:0]};
      WCLS_16: res = {{48{sg & v[15]}}, v[15:0]};
      WCLS_32: res = {{32{sg & v[31]}}, v[31:0]};
      default: res = v;
    endcase
    return res;
  endfunction

endpackage

### rtl/tale_ram.sv
module tale_ram
  import tale_pkg::*;
#(
  parameter int WIDTH = TALE_DATA_W,
  parameter int DEPTH = TALE_CAPACITY
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/tale_ctrl.sv
module tale_ctrl
  import tale_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  tale_stat_t stat,
  output tale_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_GETW  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.set_status = 1'b1;
        state_nxt      = S_DONE;
        if (stat.op == CMD_PUSH) begin
          cmd.wr_push = !stat.full;
        end else if (stat.idx_ok) begin
          case (stat.op)
            CMD_SET: begin
              cmd.wr_set = 1'b1;
            end
            CMD_GET: begin
              cmd.rd_get = 1'b1;
              state_nxt  = S_GETW;
            end
            default: begin
              // remove: compact the tail, or just drop the last entry
              if (stat.more_first) begin
                cmd.rd_first = 1'b1;
                state_nxt    = S_SHIFT;
              end else begin
                cmd.dec_count = 1'b1;
              end
            end
          endcase
        end
      end
      S_GETW: begin
        cmd.capture_rd = 1'b1;
        state_nxt      = S_DONE;
      end
      S_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (stat.more_next) begin
          cmd.rd_next = 1'b1;
        end else begin
          cmd.dec_count = 1'b1;
          state_nxt     = S_DONE;
        end
      end
      S_DONE: begin
        // hold the result until the output register frees up
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/tale_dp.sv
module tale_dp
  import tale_pkg::*;
#(
  parameter int CAPACITY = TALE_CAPACITY
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  tale_cmd_t               cmd,
  output tale_stat_t              stat,
  input  logic [1:0]              in_command,
  input  logic [TALE_INDEX_W-1:0] in_index,
  input  logic [TALE_DATA_W-1:0]  in_write_value,
  input  logic                    cfg_wen,
  input  logic [2:0]              cfg_wdata,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [TALE_DATA_W-1:0]  out_read_value,
  output logic [1:0]              out_status,
  output logic [TALE_COUNT_W-1:0] out_element_count
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = CW + 1;
  localparam int LW = CW + TALE_INDEX_W;

  logic [1:0]              op_r;
  logic [TALE_INDEX_W-1:0] idx_r;
  logic [TALE_DATA_W-1:0]  wv_r;
  logic [AW-1:0]           k_r;
  logic [CW-1:0]           count_r;
  logic [CW-1:0]           count_nxt;
  logic [2:0]              type_r;
  logic [1:0]              status_r;
  logic [TALE_DATA_W-1:0]  rd_r;
  logic                    out_valid_r;
  logic [TALE_DATA_W-1:0]  out_rv_r;
  logic [1:0]              out_st_r;
  logic [TALE_COUNT_W-1:0] out_cnt_r;

  logic [LW-1:0]           idx_x;
  logic [LW-1:0]           count_x;
  logic [AW-1:0]           idx_addr;
  logic                    idx_ok;
  logic                    full;
  logic [1:0]              status_nxt;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [TALE_DATA_W-1:0]  ram_wdata;
  logic                    ram_re;
  logic [AW-1:0]           ram_raddr;
  logic [TALE_DATA_W-1:0]  ram_rdata;

  assign idx_x    = LW'(idx_r);
  assign count_x  = LW'(count_r);
  assign idx_addr = idx_x[AW-1:0];
  assign idx_ok   = (idx_x < count_x);
  assign full     = (count_r == CW'(CAPACITY));

  assign stat.op         = op_r;
  assign stat.idx_ok     = idx_ok;
  assign stat.full       = full;
  assign stat.more_first = ((idx_x + LW'(1)) < count_x);
  assign stat.more_next  = ((SW'(k_r) + SW'(2)) < SW'(count_r));
  assign stat.out_free   = !out_valid_r || out_ready;

  always_comb begin
    if (op_r == CMD_PUSH) begin
      status_nxt = full ? ST_FULL : ST_OK;
    end else begin
      status_nxt = idx_ok ? ST_OK : ST_RANGE;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.wr_push) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.dec_count) begin
      count_nxt = count_r - CW'(1);
    end
  end

  // store port: shift moves rdata down one slot, set/push write the cut value
  always_comb begin
    ram_we    = cmd.wr_set | cmd.wr_push | cmd.shift_step;
    ram_waddr = idx_addr;
    ram_wdata = tale_cut(wv_r, type_r);
    if (cmd.shift_step) begin
      ram_waddr = k_r;
      ram_wdata = ram_rdata;
    end else if (cmd.wr_push) begin
      ram_waddr = count_r[AW-1:0];
    end
    ram_re    = cmd.rd_get | cmd.rd_first | cmd.rd_next;
    ram_raddr = idx_addr;
    if (cmd.rd_next) begin
      ram_raddr = k_r + AW'(2);
    end else if (cmd.rd_first) begin
      ram_raddr = idx_addr + AW'(1);
    end
  end

  tale_ram #(
    .WIDTH (TALE_DATA_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      type_r      <= TYPE_INT;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cfg_wen) begin
        type_r <= cfg_wdata;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r  <= in_command;
      idx_r <= in_index;
      wv_r  <= in_write_value;
    end
    if (cmd.set_status) begin
      status_r <= status_nxt;
      rd_r     <= '0;
      k_r      <= idx_addr;
    end else if (cmd.shift_step) begin
      k_r <= k_r + AW'(1);
    end
    if (cmd.capture_rd) begin
      rd_r <= tale_extend(ram_rdata, type_r);
    end
    if (cmd.load_out) begin
      out_rv_r  <= rd_r;
      out_st_r  <= status_r;
      out_cnt_r <= count_x[TALE_COUNT_W-1:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_read_value    = out_rv_r;
  assign out_status        = out_st_r;
  assign out_element_count = out_cnt_r;

endmodule

### rtl/typed_array_list_engine_top.sv
// Flow: set, push and any rejected command pass from accept through EXEC to DONE;
// get also passes through GETW, for the registered store read.
// Remove at index i with n entries held shifts the n - 1 - i entries above i in SHIFT: the single
// store port moves one entry down per cycle. One command is in flight at a time.
// Synchronous active-low reset empties the list and sets the element type to int;
// store contents are not cleared, since only positions below the count are ever read.
module typed_array_list_engine_top
  import tale_pkg::*;
#(
  parameter int CAPACITY = TALE_CAPACITY
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_tvalid,
  output logic                    in_tready,
  // [1:0] command, [11:2] index, [75:12] write_value, [79:76] zero
  input  logic [TALE_TDATA_W-1:0] in_tdata,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  // [63:0] read_value, [65:64] status, [76:66] element_count, [79:77] zero
  output logic [TALE_TDATA_W-1:0] out_tdata,
  input  logic                    cfg_wen,
  input  logic [2:0]              cfg_wdata
);

  tale_cmd_t               cmd;
  tale_stat_t              stat;
  logic [TALE_DATA_W-1:0]  read_value;
  logic [1:0]              status;
  logic [TALE_COUNT_W-1:0] element_count;

  tale_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tale_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_command        (in_tdata[1:0]),
    .in_index          (in_tdata[11:2]),
    .in_write_value    (in_tdata[75:12]),
    .cfg_wen           (cfg_wen),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_tvalid),
    .out_ready         (out_tready),
    .out_read_value    (read_value),
    .out_status        (status),
    .out_element_count (element_count)
  );

  assign out_tdata = {3'd0, element_count, status, read_value};

endmodule
